// ----- src/sha256_pkg.sv -----
// Package with SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package sha256_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CountW = 61;
	localparam int unsigned NumRounds = 64;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned HashWords = 8;
	localparam int unsigned BlkAddrW = $clog2(BlockWords);
	localparam int unsigned RoundW = $clog2(NumRounds);
	localparam int unsigned HashIdxW = $clog2(HashWords);

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_FINISH = 1'b1;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [WordW-1:0] word_t;

	localparam word_t ROUND_K [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic  start;
		logic  busy;
		logic  done;
	} core_ctl_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t ssig0(input word_t x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

// ----- src/sha256_message_hasher_top.sv -----
// Top level of the byte-serial SHA-256 hasher.
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | opcode, data_byte
//  out     | out_valid | out_stall | digest_word, word_index, last_word
// A byte that does not close a block is taken without stalling the input.
// A byte that closes a block stalls the input while the core is started, loads the block
// from memory, runs 64 rounds, adds into the hash and hands the result back.
// A finish pads the block byte by byte, runs one or two compressions and then
// offers eight result items, one per cycle while out_stall is low.
// Reset clears the control state and restores the initial hash words.
`timescale 1ns / 1ps
module sha256_message_hasher_top
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PAD  = 6'b000010,
		S_LEN  = 6'b000100,
		S_HASH = 6'b001000,
		S_WAIT = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	word_t hash_q [HashWords];
	logic [CountW-1:0] count_q;
	logic [5:0] pos_q;
	logic [63:0] bits_q;
	logic fin_q, last_blk_q;
	logic [HashIdxW-1:0] oidx_q;
	word_t wacc_q;

	core_ctl_t ctl;
	word_t hash_new [HashWords];
	logic start;
	logic blk_we;
	logic [BlkAddrW-1:0] blk_addr;
	word_t blk_wdata;
	logic [7:0] wr_byte;
	logic in_acc;
	word_t acc_next;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;

	// Bytes gather in a word register and go to memory when the word fills.
	always_comb begin
		wr_byte = (state_q == S_IDLE) ? ((opcode == OP_FINISH) ? PAD_BYTE : data_byte)
			: 8'h00;
		acc_next = {wacc_q[23:0], wr_byte};
		blk_we = 1'b0;
		blk_addr = pos_q[5:2];
		blk_wdata = acc_next;
		if (state_q == S_IDLE && in_acc && pos_q[1:0] == 2'd3) blk_we = 1'b1;
		if (state_q == S_PAD && pos_q[1:0] == 2'd3) blk_we = 1'b1;
		if (state_q == S_LEN) begin
			blk_we = 1'b1;
			blk_addr = pos_q[0] ? BlkAddrW'(15) : BlkAddrW'(14);
			blk_wdata = pos_q[0] ? bits_q[31:0] : bits_q[63:32];
		end
	end

	assign start = (state_q == S_HASH);

	sha256_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.hash_in  (hash_q),
		.blk_we   (blk_we),
		.blk_addr (blk_addr),
		.blk_wdata(blk_wdata),
		.ctl      (ctl),
		.hash_out (hash_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pos_q <= '0;
			fin_q <= 1'b0;
			last_blk_q <= 1'b0;
			oidx_q <= '0;
			for (int i = 0; i < HashWords; i++) hash_q[i] <= INIT_HASH[i];
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						pos_q <= pos_q + 1'b1;
						if (opcode == OP_APPEND) begin
							count_q <= count_q + 1'b1;
							if (pos_q == 6'd63) begin
								state_q <= S_HASH;
								fin_q <= 1'b0;
							end
						end else begin
							fin_q <= 1'b1;
							bits_q <= {count_q, 3'b000};
							if (pos_q == 6'd63) begin
								state_q <= S_HASH;
								last_blk_q <= 1'b0;
							end else if (pos_q == 6'd55) begin
								// The pad byte closed word 13, so the length goes next.
								state_q <= S_LEN;
								pos_q <= '0;
							end else begin
								state_q <= S_PAD;
							end
						end
					end
				end
				S_PAD: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == 6'd63) begin
						state_q <= S_HASH;
						last_blk_q <= 1'b0;
					end else if (pos_q == 6'd55 && pos_q[5:0] >= 6'd55) begin
						// Length fits in this block: stop after byte 55.
						state_q <= S_LEN;
						pos_q <= '0;
					end
				end
				S_LEN: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q[0]) begin
						state_q <= S_HASH;
						last_blk_q <= 1'b1;
						pos_q <= '0;
					end
				end
				S_HASH: state_q <= S_WAIT;
				S_WAIT: begin
					if (ctl.done) begin
						for (int i = 0; i < HashWords; i++) hash_q[i] <= hash_new[i];
						if (!fin_q) begin
							state_q <= S_IDLE;
						end else if (last_blk_q) begin
							state_q <= S_OUT;
							oidx_q <= '0;
						end else begin
							// Block held no room for the length: zero fill a fresh one.
							state_q <= S_PAD;
							pos_q <= '0;
						end
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 1'b1;
						if (oidx_q == HashIdxW'(HashWords - 1)) begin
							state_q <= S_IDLE;
							fin_q <= 1'b0;
							last_blk_q <= 1'b0;
							count_q <= '0;
							pos_q <= '0;
							for (int i = 0; i < HashWords; i++) hash_q[i] <= INIT_HASH[i];
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE && in_acc) || state_q == S_PAD) wacc_q <= acc_next;
	end

	assign out_valid = (state_q == S_OUT);
	assign digest_word = hash_q[oidx_q];
	assign word_index = oidx_q;
	assign last_word = (oidx_q == HashIdxW'(HashWords - 1));

`ifndef SYNTH
	a_stall_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.busy |-> in_stall) else $error("input open while core busy");
	a_out_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fin_q && last_blk_q) else $error("digest without finish");
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_word) |=> count_q == '0)
		else $error("count not cleared");
`endif

endmodule

// ----- src/sha256_round.sv -----
// Round engine: 64 rounds over the block held in a one-port-read schedule memory.
`timescale 1ns / 1ps
module sha256_round
	import sha256_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  word_t                hash_in [HashWords],
	input  logic                 blk_we,
	input  logic [BlkAddrW-1:0]  blk_addr,
	input  word_t                blk_wdata,
	output core_ctl_t            ctl,
	output word_t                hash_out [HashWords]
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_ADD   = 4'b1000
	} state_t;

	state_t state_q;
	logic [RoundW-1:0] rnd_q;
	logic [BlkAddrW:0] ld_q;
	word_t win_q [BlockWords];
	word_t v_q [HashWords];
	word_t out_q [HashWords];
	logic done_q;

	// The block store: a 16-entry memory holding the words of the message block.
	word_t blk_mem [BlockWords];

	word_t w_cur, w_new, t1, t2, ch, maj;

	// Schedule word for this round comes from the shift window of 16 words.
	always_comb begin
		w_new = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
		w_cur = win_q[0];
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + bsig1(v_q[4]) + ch + ROUND_K[rnd_q] + w_cur;
		t2 = bsig0(v_q[0]) + maj;
	end

	word_t rd_s1;
	always_ff @(posedge clk) begin
		if (blk_we) begin
			blk_mem[blk_addr] <= blk_wdata;
		end
		rd_s1 <= blk_mem[ld_q[BlkAddrW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			ld_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOAD;
						ld_q <= '0;
					end
				end
				ST_LOAD: begin
					ld_q <= ld_q + 1'b1;
					if (ld_q == (BlkAddrW+1)'(BlockWords)) begin
						state_q <= ST_ROUND;
						rnd_q <= '0;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RoundW'(NumRounds - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < HashWords; i++) v_q[i] <= hash_in[i];
			end
			ST_LOAD: begin
				// Read data is registered, so it arrives in the cycle after its address.
				if (ld_q != '0) begin
					for (int i = 0; i < BlockWords - 1; i++) win_q[i] <= win_q[i+1];
					win_q[BlockWords-1] <= rd_s1;
				end
			end
			ST_ROUND: begin
				for (int i = 0; i < BlockWords - 1; i++) win_q[i] <= win_q[i+1];
				win_q[BlockWords-1] <= w_new;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			ST_ADD: begin
				for (int i = 0; i < HashWords; i++) out_q[i] <= hash_in[i] + v_q[i];
			end
			default: ;
		endcase
	end

	assign ctl.start = start;
	assign ctl.busy = (state_q != ST_IDLE);
	assign ctl.done = done_q;
	assign hash_out = out_q;

`ifndef SYNTH
	a_done_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |=> done_q) else $error("done missing after add");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !start) else $error("start while busy");
	a_round_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && $past(state_q) == ST_LOAD) |-> rnd_q == '0)
		else $error("round counter not cleared");
`endif

endmodule

// ----- tb/sv/sha256_message_hasher_top_test.sv -----
// Self-checking testbench for the byte-serial SHA-256 hasher.
`timescale 1ns / 1ps
module sha256_message_hasher_top_test;
	import sha256_pkg::*;

	typedef struct {
		word_t      dword;
		logic [2:0] idx;
		logic       last;
	} digest_item_t;

	// Tracks the hash state per accepted item and holds the digest words still due.
	class digest_scoreboard;
		word_t        hash_st [HashWords];
		word_t        blk [BlockWords];
		logic [60:0]  nbytes;
		digest_item_t due_words [$];
		int           errors;

		function new();
			errors = 0;
			nbytes = '0;
			foreach (hash_st[i]) hash_st[i] = INIT_HASH[i];
			foreach (blk[i]) blk[i] = '0;
		endfunction

		function word_t rr(word_t x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress_block();
			word_t w [64];
			word_t v [8];
			word_t t1, t2, s0, s1;
			for (int i = 0; i < 16; i++) w[i] = blk[i];
			for (int i = 16; i < 64; i++) begin
				s0 = rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = s1 + w[i-7] + s0 + w[i-16];
			end
			foreach (v[i]) v[i] = hash_st[i];
			for (int i = 0; i < 64; i++) begin
				t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
				t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			foreach (v[i]) hash_st[i] = hash_st[i] + v[i];
		endfunction

		function void place_byte(int pos, logic [7:0] b);
			int sh;
			sh = (3 - (pos % 4)) * 8;
			blk[pos/4] = (blk[pos/4] & ~(32'hff << sh)) | (word_t'(b) << sh);
		endfunction

		function void note_input(logic op, logic [7:0] b);
			int pos;
			logic [63:0] bits;
			digest_item_t d;
			pos = nbytes[5:0];
			if (op == OP_APPEND) begin
				place_byte(pos, b);
				nbytes = nbytes + 61'd1;
				if (pos == 63) compress_block();
				return;
			end
			bits = {nbytes, 3'b000};
			place_byte(pos, PAD_BYTE);
			for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
			if (pos >= 56) begin
				compress_block();
				foreach (blk[i]) blk[i] = '0;
			end
			blk[14] = bits[63:32];
			blk[15] = bits[31:0];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				d.dword = hash_st[i];
				d.idx = 3'(i);
				d.last = (i == 7);
				due_words.push_back(d);
			end
			foreach (hash_st[i]) hash_st[i] = INIT_HASH[i];
			nbytes = '0;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(word_t dw, logic [2:0] idx, logic last);
			digest_item_t d;
			if (due_words.size() == 0) begin
				report_mismatch($sformatf("unexpected digest word %h", dw));
				return;
			end
			d = due_words.pop_front();
			if (dw !== d.dword)
				report_mismatch($sformatf("digest_word %h, want %h", dw, d.dword));
			if (idx !== d.idx)
				report_mismatch($sformatf("word_index %0d, want %0d", idx, d.idx));
			if (last !== d.last)
				report_mismatch($sformatf("last_word %b, want %b", last, d.last));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        opcode = 0;
	logic [7:0]  data_byte = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_scoreboard sb = new();
	int idle_cycles = 0;
	localparam int IdleLimit = 20000;

	sha256_message_hasher_top uut (.*);

	always #1 clk = ~clk;

	// One item; the gap before it is random, and valid stays up between back-to-back items.
	task automatic send_item(logic op, logic [7:0] b);
		int gap;
		gap = $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(op, b);
	endtask

	task automatic send_message(int len);
		for (int i = 0; i < len; i++) send_item(OP_APPEND, 8'($urandom_range(0, 255)));
		send_item(OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(digest_word, word_index, last_word);
	end

	// Receiver stall: a random hold per result, with quiet stretches of none.
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			hold = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 4);
			if (hold > 0) begin
				out_stall <= 1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("sha256_message_hasher_top_test: done, errors");
			$finish;
		end
	end

	initial begin
		int items;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: empty message, one byte, tail lengths near the padding edge.
		send_message(0);
		send_item(OP_APPEND, 8'h00);
		send_item(OP_FINISH, 8'hff);
		send_message(55);
		send_message(56);
		send_message(63);
		send_message(64);
		for (int i = 0; i < 8; i++) send_item(OP_APPEND, 8'h01 << i);
		send_item(OP_APPEND, 8'hff);
		send_item(OP_FINISH, 8'h00);
		// Let the sender wait until every digest word is back.
		in_valid <= 0;
		while (sb.due_words.size() != 0) @(posedge clk);
		items = 0;
		while (items < 140) begin
			int len;
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
			send_message(len);
			items += len + 1;
		end
		in_valid <= 0;
		while (sb.due_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) $display("sha256_message_hasher_top_test: done, clean");
		else $display("sha256_message_hasher_top_test: done, errors");
		$finish;
	end

endmodule
